// ===== src/i2cm_pkg.sv =====
// i2cm_pkg: shared types and codes for the byte-level I2C master.
// No dependencies; imported by every module of the block.
package i2cm_pkg;

    localparam int PADDR_W = 3;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_ST_C    = 4'd3;
    localparam logic [3:0] PH_SP_A    = 4'd4;
    localparam logic [3:0] PH_SP_B    = 4'd5;
    localparam logic [3:0] PH_SP_C    = 4'd6;
    localparam logic [3:0] PH_WR_LOW  = 4'd7;
    localparam logic [3:0] PH_WR_HIGH = 4'd8;
    localparam logic [3:0] PH_WA_LOW  = 4'd9;
    localparam logic [3:0] PH_WA_HIGH = 4'd10;
    localparam logic [3:0] PH_RD_LOW  = 4'd11;
    localparam logic [3:0] PH_RD_HIGH = 4'd12;
    localparam logic [3:0] PH_RD_HOLD = 4'd13;
    localparam logic [3:0] PH_RA_LOW  = 4'd14;
    localparam logic [3:0] PH_RA_HIGH = 4'd15;

    localparam logic [7:0] HALF_RESET = 8'd5;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [PADDR_W-1:0] ADDR_HALF = 3'd0;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_received;
    } out_t;

    typedef struct packed {
        logic       busy;
    } status_t;

endpackage

// ===== src/i2cm_apb_regs.sv =====
// i2cm_apb_regs: APB register file holding the half-period setting.
// Depends on i2cm_pkg.
module i2cm_apb_regs
    import i2cm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [7:0]         half_period
);

    logic [7:0] half_reg;
    logic [7:0] half_next;
    logic       hit;

    assign hit    = (paddr[PADDR_W-1:2] == ADDR_HALF[PADDR_W-1:2]);
    assign pready = 1'b1;

    always_comb begin
        half_next = half_reg;
        if (psel && penable && pwrite && hit) begin
            half_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= HALF_RESET;
        end else begin
            half_reg <= half_next;
        end
    end

    assign prdata      = hit ? {24'd0, half_reg} : 32'd0;
    assign half_period = half_reg;

endmodule

// ===== src/i2cm_phase_fsm.sv =====
// i2cm_phase_fsm: bus phase sequencer, bit counter, shifter and pin state.
// Updates on each accepted request and produces the next result. Uses i2cm_pkg.
module i2cm_phase_fsm
    import i2cm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  in_t        req,
    input  logic [7:0] half_period,
    output out_t       res,
    output status_t    status
);

    logic [3:0] phase_reg,  phase_next;
    logic [3:0] bit_reg,    bit_next;
    logic [7:0] shift_reg,  shift_next;
    logic [7:0] tick_reg,   tick_next;
    logic       ack_reg,    ack_next;
    logic       scl_reg,    scl_next;
    logic       sda_reg,    sda_next;
    logic       en_reg,     en_next;
    logic       ram_reg,    ram_next;
    logic [7:0] rx_reg,     rx_next;
    logic       done;
    logic [7:0] tick_inc;
    logic [3:0] bit_inc;

    assign tick_inc = tick_reg + 8'd1;
    assign bit_inc  = bit_reg + 4'd1;

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        en_next    = en_reg;
        ram_next   = ram_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        if (phase_reg == PH_IDLE) begin
            tick_next = 8'd0;
            bit_next  = 4'd0;
            case (req.kind)
                KIND_START: begin
                    en_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                    phase_next = PH_ST_A;
                end
                KIND_STOP: begin
                    en_next = 1'b1; sda_next = 1'b0; scl_next = 1'b0;
                    phase_next = PH_SP_A;
                end
                KIND_WRITE: begin
                    scl_next   = 1'b0;
                    en_next    = 1'b1;
                    sda_next   = req.data_byte[7];
                    shift_next = {req.data_byte[6:0], 1'b0};
                    phase_next = PH_WR_LOW;
                end
                KIND_READ: begin
                    shift_next = 8'd0;
                    ram_next   = req.send_ack;
                    scl_next   = 1'b0;
                    en_next    = 1'b0;
                    phase_next = PH_RD_LOW;
                end
                default: begin
                end
            endcase
        end else if (tick_inc != half_period) begin
            tick_next = tick_inc;
        end else begin
            tick_next = 8'd0;
            case (phase_reg)
                PH_ST_A: begin sda_next = 1'b0; phase_next = PH_ST_B; end
                PH_ST_B: begin scl_next = 1'b0; phase_next = PH_ST_C; end
                PH_ST_C: done = 1'b1;
                PH_SP_A: begin scl_next = 1'b1; phase_next = PH_SP_B; end
                PH_SP_B: begin sda_next = 1'b1; phase_next = PH_SP_C; end
                PH_SP_C: done = 1'b1;
                PH_WR_LOW: begin scl_next = 1'b1; phase_next = PH_WR_HIGH; end
                PH_WR_HIGH: begin
                    bit_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        scl_next   = 1'b0;
                        en_next    = 1'b0;
                        phase_next = PH_WA_LOW;
                    end else begin
                        scl_next   = 1'b0;
                        en_next    = 1'b1;
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_WR_LOW;
                    end
                end
                PH_WA_LOW: begin scl_next = 1'b1; phase_next = PH_WA_HIGH; end
                PH_WA_HIGH: begin
                    ack_next = req.sda_in;
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                PH_RD_LOW: begin scl_next = 1'b1; phase_next = PH_RD_HIGH; end
                PH_RD_HIGH: begin
                    shift_next = {shift_reg[6:0], req.sda_in};
                    phase_next = PH_RD_HOLD;
                end
                PH_RD_HOLD: begin
                    bit_next = bit_inc;
                    scl_next = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        en_next    = 1'b1;
                        sda_next   = !ram_reg;
                        phase_next = PH_RA_LOW;
                    end else begin
                        en_next    = 1'b0;
                        phase_next = PH_RD_LOW;
                    end
                end
                PH_RA_LOW: begin scl_next = 1'b1; phase_next = PH_RA_HIGH; end
                PH_RA_HIGH: begin
                    scl_next = 1'b0;
                    en_next  = 1'b1;
                    sda_next = 1'b1;
                    rx_next  = shift_reg;
                    done     = 1'b1;
                end
                default: begin
                end
            endcase
            if (done) begin
                phase_next = PH_IDLE;
                bit_next   = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            tick_reg  <= 8'd0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            en_reg    <= 1'b1;
            ram_reg   <= 1'b0;
            rx_reg    <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            en_reg    <= en_next;
            ram_reg   <= ram_next;
            rx_reg    <= rx_next;
        end
    end

    assign res.scl           = scl_next;
    assign res.sda_out       = sda_next;
    assign res.sda_drive     = en_next;
    assign res.busy_res      = (phase_next != PH_IDLE);
    assign res.done_res      = done;
    assign res.rx_byte       = rx_next;
    assign res.nack_received = ack_next;

    assign status.busy  = (phase_reg != PH_IDLE);

endmodule

// ===== src/i2cm_out_stage.sv =====
// i2cm_out_stage: result register with valid/ready handshake.
// Depends on i2cm_pkg.
module i2cm_out_stage
    import i2cm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  out_t res,
    input  logic m_ready,
    output logic m_valid,
    output out_t m_data,
    output logic room
);

    logic valid_reg, valid_next;
    out_t data_reg;

    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== src/i2c_master_byte_engine_unit.sv =====
// i2c_master_byte_engine_unit: top level of the byte-level I2C master.
// Depends on i2cm_pkg, i2cm_apb_regs, i2cm_phase_fsm, i2cm_out_stage.
//
//   channel   dir   handshake          payload
//   s_        in    s_valid/s_ready    s_data (in_t: kind, data_byte, send_ack, sda_in)
//   m_        out   m_valid/m_ready    m_data (out_t: pins, busy, done, rx, nack)
//   apb       in    psel/penable       paddr, pwdata, prdata (half period at 0x0)
//
// One request per cycle while s_ready is high; its result is registered and valid the next cycle.
// The phase state and the result register update in the same edge.
// s_ready is high when the result register is empty or being drained.
// Reset clears the phase state, pins go idle high, half period returns to 5.
module i2c_master_byte_engine_unit
    import i2cm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       accept;
    logic       room;
    logic [7:0] half_period;
    out_t       res;
    status_t    status;

    assign s_ready = room;
    assign accept  = s_valid && room;

    i2cm_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .half_period (half_period)
    );

    i2cm_phase_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .req         (s_data),
        .half_period (half_period),
        .res         (res),
        .status      (status)
    );

    i2cm_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .room    (room)
    );

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("result register not loaded after request");

    a_idle_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !status.busy |=> !m_data.done_res)
        else $error("done raised for a request taken while idle");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("busy still set on done result");

    a_idle_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && status.busy && s_data.kind != KIND_TICK |=> m_data.busy_res
            || m_data.done_res)
        else $error("command while busy disturbed the sequence");

endmodule
